FILE: rtl/mwpe_pkg.sv
// shared types and constants for the multichannel ws2812 pulse encoder
// no dependencies
package mwpe_pkg;

  localparam int CHANNELS = 3;
  localparam int LANES = 3;
  localparam int USED_LANES = (CHANNELS > LANES) ? LANES : CHANNELS;
  localparam logic [LANES-1:0] LANE_MASK = LANES'((1 << USED_LANES) - 1);

  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] REQ_SYMBOL = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_RESET = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_T0H = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T1H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd4;

  typedef enum logic [1:0] {
    KIND_SYMBOL,
    KIND_BYTE,
    KIND_RESET
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [LANES-1:0][7:0] bytes;
  } entry_t;

  typedef struct packed {
    logic [7:0] t0h;
    logic [7:0] t1h;
    logic [7:0] period;
    logic [15:0] reset_len;
    logic [LANES-1:0] act;
  } cfg_t;

endpackage

FILE: rtl/mwpe_front.sv
// front end: classifies input transfers into queue entries
// depends on mwpe_pkg
module mwpe_front import mwpe_pkg::*; (
  input  logic [1:0] req_type,
  input  logic [LANES-1:0] symbol_bits,
  input  logic [7:0] chan0_byte,
  input  logic [7:0] chan1_byte,
  input  logic [7:0] chan2_byte,
  output logic push_ok,
  output entry_t entry
);

  always_comb begin
    push_ok = 1'b1;
    entry.kind = KIND_SYMBOL;
    entry.bytes = '0;
    case (req_type)
      REQ_SYMBOL: begin
        // single symbol sits in the msb, the bit the back end reads first; the symbol kind stops it after that bit
        for (int i = 0; i < LANES; i++) begin
          entry.bytes[i] = {symbol_bits[i], 7'd0};
        end
      end
      REQ_BYTE: begin
        entry.kind = KIND_BYTE;
        entry.bytes = {chan2_byte, chan1_byte, chan0_byte};
      end
      REQ_RESET: begin
        entry.kind = KIND_RESET;
      end
      default: begin
        push_ok = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/mwpe_fifo.sv
// two-entry queue between front and back
// depends on mwpe_pkg
module mwpe_fifo import mwpe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  entry_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output entry_t head
);

  entry_t mem_r [2];
  logic wr_ptr_r;
  logic rd_ptr_r;
  logic [1:0] count_r;

  assign full = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10: count_r <= count_r + 2'd1;
        2'b01: count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/mwpe_back.sv
// back end: expands queue entries into timed pin-level segments
// depends on mwpe_pkg
module mwpe_back import mwpe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic head_valid,
  input  entry_t head,
  output logic pop,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic out_tlast
);

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_SPLIT,
    PH_LOW
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic [2:0] sym_idx_r, sym_idx_nxt;
  logic out_valid_r;
  logic [LANES-1:0] levels_r;
  logic [15:0] dur_r;
  logic last_r;

  logic [LANES-1:0] sym, e, lv;
  logic uniform, zero_first, fin, sym_done, fire;
  logic [7:0] th, lo, hi, low_ref, low;
  logic [15:0] dur;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sym[i] = head.bytes[i][sym_idx_r];
    end
    e = sym & cfg.act;
    uniform = (e == '0) || (e == cfg.act);
    zero_first = (cfg.t0h <= cfg.t1h);
    th = (e != '0) ? cfg.t1h : cfg.t0h;
    lo = zero_first ? cfg.t0h : cfg.t1h;
    hi = zero_first ? cfg.t1h : cfg.t0h;
    low_ref = uniform ? th : hi;
    low = (cfg.period > low_ref) ? cfg.period - low_ref : 8'd0;
    fin = (head.kind != KIND_BYTE) || (sym_idx_r == 3'd0);

    lv = '0;
    dur = '0;
    sym_done = 1'b0;
    phase_nxt = phase_r;
    sym_idx_nxt = sym_idx_r;
    if (head.kind == KIND_RESET) begin
      dur = cfg.reset_len;
      sym_done = 1'b1;
    end else begin
      case (phase_r)
        PH_HIGH: begin
          lv = cfg.act;
          dur = {8'd0, uniform ? th : lo};
          phase_nxt = uniform ? PH_LOW : PH_SPLIT;
        end
        PH_SPLIT: begin
          lv = zero_first ? e : (cfg.act & ~e);
          dur = {8'd0, hi - lo};
          phase_nxt = PH_LOW;
        end
        PH_LOW: begin
          dur = {8'd0, low};
          sym_done = 1'b1;
        end
        default: begin
          phase_nxt = PH_HIGH;
        end
      endcase
    end
    if (sym_done) begin
      phase_nxt = PH_HIGH;
      sym_idx_nxt = fin ? 3'd7 : sym_idx_r - 3'd1;
    end
  end

  assign fire = head_valid && (!out_valid_r || out_tready);
  assign pop = fire && sym_done && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HIGH;
      sym_idx_r <= 3'd7;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        sym_idx_r <= sym_idx_nxt;
        out_valid_r <= 1'b1;
        levels_r <= lv;
        dur_r <= dur;
        last_r <= sym_done && fin;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {5'd0, dur_r, levels_r};
  assign out_tlast = last_r;

endmodule

FILE: rtl/multichannel_ws2812_pulse_encoder.sv
// top level of the multichannel ws2812 pulse encoder: config registers and wiring
// depends on mwpe_pkg, mwpe_front, mwpe_fifo, mwpe_back
//
// channel  direction  ports                         contents
// in       slave      in_tvalid/tready/tdata/tuser  tuser: req_type; tdata: symbol and bytes
// out      master     out_tvalid/tready/tdata/tlast tdata: levels and duration; tlast: last
// cfg      write      cfg_we/cfg_index/cfg_wdata    timing and channel mask registers
//
// one segment per cycle while the output is not stalled and the queue holds a request: a symbol
// request yields 2 or 3 segments, a byte request 16 to 24, a reset request 1; the back end sets that pace
// reset returns the registers to their defaults and empties the queue
// a stalled output holds its register; the two-entry queue keeps taking requests until full
module multichannel_ws2812_pulse_encoder import mwpe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // symbol_bits, chan0_byte, chan1_byte, chan2_byte
  input  logic [1:0] in_tuser,             // req_type
  output logic out_tvalid,
  input  logic out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // channel_levels, duration
  output logic out_tlast,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  cfg_t cfg_view;
  logic push_ok, full, push, pop, head_valid;
  entry_t entry, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.t0h <= 8'd8;
      cfg_r.t1h <= 8'd16;
      cfg_r.period <= 8'd25;
      cfg_r.reset_len <= 16'd1000;
      cfg_r.act <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_T0H: cfg_r.t0h <= cfg_wdata[7:0];
        REG_T1H: cfg_r.t1h <= cfg_wdata[7:0];
        REG_PERIOD: cfg_r.period <= cfg_wdata[7:0];
        REG_RESET: cfg_r.reset_len <= cfg_wdata;
        REG_ACTIVE: cfg_r.act <= cfg_wdata[LANES-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    cfg_view = cfg_r;
    cfg_view.act = cfg_r.act & LANE_MASK;
  end

  assign in_tready = !full;
  assign push = in_tvalid && in_tready && push_ok;

  mwpe_front u_front (
    .req_type(in_tuser),
    .symbol_bits(in_tdata[2:0]),
    .chan0_byte(in_tdata[10:3]),
    .chan1_byte(in_tdata[18:11]),
    .chan2_byte(in_tdata[26:19]),
    .push_ok(push_ok),
    .entry(entry)
  );

  mwpe_fifo u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_data(entry),
    .full(full),
    .pop(pop),
    .head_valid(head_valid),
    .head(head)
  );

  mwpe_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_view),
    .head_valid(head_valid),
    .head(head),
    .pop(pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

endmodule

FILE: dv/tb_top.sv
// testbench for multichannel_ws2812_pulse_encoder: directed and random requests with
// random idling on both streams, every segment checked against an in-bench encoder
// depends on mwpe_pkg and the rtl top level
module tb_top;
  import mwpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RUN_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [2:0] levels;
    logic [15:0] duration;
    logic last;
  } segment_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;   // symbol_bits, chan0_byte, chan1_byte, chan2_byte
  logic [1:0] in_tuser;             // req_type
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata; // channel_levels, duration
  logic out_tlast;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  segment_t pending_segs[$];
  logic [7:0] mirror_t0h;
  logic [7:0] mirror_t1h;
  logic [7:0] mirror_period;
  logic [15:0] mirror_gap;
  logic [2:0] mirror_act;
  int errors = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  multichannel_ws2812_pulse_encoder i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_segment(input logic [2:0] lv, input logic [15:0] dur,
                                       input logic fin);
    segment_t s;
    s.levels = lv;
    s.duration = dur;
    s.last = fin;
    pending_segs.push_back(s);
  endfunction

  function automatic void encode_symbol(input logic [2:0] bits, input logic fin);
    logic [2:0] act;
    logic [2:0] ones;
    logic [7:0] th;
    logic [7:0] lo;
    logic [7:0] hi;
    act = mirror_act & LANE_MASK;
    ones = bits & act;
    if (ones == 3'b000 || ones == act) begin
      th = (ones != 3'b000) ? mirror_t1h : mirror_t0h;
      push_segment(act, 16'(th), 1'b0);
      push_segment(3'b000, (mirror_period > th) ? 16'(mirror_period - th) : 16'd0, fin);
    end else begin
      if (mirror_t0h <= mirror_t1h) begin
        lo = mirror_t0h;
        hi = mirror_t1h;
        push_segment(act, 16'(lo), 1'b0);
        push_segment(ones, 16'(hi - lo), 1'b0);
      end else begin
        lo = mirror_t1h;
        hi = mirror_t0h;
        push_segment(act, 16'(lo), 1'b0);
        push_segment(act & ~ones, 16'(hi - lo), 1'b0);
      end
      push_segment(3'b000, (mirror_period > hi) ? 16'(mirror_period - hi) : 16'd0, fin);
    end
  endfunction

  function automatic void encode_request(input logic [1:0] kind,
                                         input logic [IN_DATA_W-1:0] data);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = data[10:3];
    b1 = data[18:11];
    b2 = data[26:19];
    case (kind)
      REQ_SYMBOL: encode_symbol(data[2:0], 1'b1);
      REQ_BYTE: begin
        for (int s = 7; s >= 0; s--) begin
          encode_symbol({b2[s], b1[s], b0[s]}, s == 0);
        end
      end
      REQ_RESET: push_segment(3'b000, mirror_gap, 1'b1);
      default: ;
    endcase
  endfunction

  // mirrors register writes, predicts on input transfers, checks output transfers
  always @(posedge clk) begin
    segment_t want;
    if (!rst_n) begin
      mirror_t0h = 8'd8;
      mirror_t1h = 8'd16;
      mirror_period = 8'd25;
      mirror_gap = 16'd1000;
      mirror_act = 3'd0;
      pending_segs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_T0H: mirror_t0h = cfg_wdata[7:0];
          REG_T1H: mirror_t1h = cfg_wdata[7:0];
          REG_PERIOD: mirror_period = cfg_wdata[7:0];
          REG_RESET: mirror_gap = cfg_wdata;
          REG_ACTIVE: mirror_act = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        encode_request(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (pending_segs.size() == 0) begin
          $display("%0t: unexpected segment levels=%0h duration=%0d last=%0b", $time,
                   out_tdata[2:0], out_tdata[18:3], out_tlast);
          errors++;
        end else begin
          want = pending_segs.pop_front();
          if (out_tdata[2:0] !== want.levels) begin
            $display("%0t: levels expected %0h actual %0h", $time, want.levels,
                     out_tdata[2:0]);
            errors++;
          end
          if (out_tdata[18:3] !== want.duration) begin
            $display("%0t: duration expected %0d actual %0d", $time, want.duration,
                     out_tdata[18:3]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  // output side: random stall before each transfer
  initial begin
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d segments outstanding", $time, pending_segs.size());
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic send_req(input logic [1:0] kind, input logic [2:0] bits,
                          input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {5'b00000, b2, b1, b0, bits};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_timing(input logic [7:0] t0h, input logic [7:0] t1h,
                             input logic [7:0] period, input logic [15:0] gap_len,
                             input logic [2:0] act);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [15:0] val [5];
    idx = '{REG_T0H, REG_T1H, REG_PERIOD, REG_RESET, REG_ACTIVE};
    val = '{16'(t0h), 16'(t1h), 16'(period), gap_len, 16'(act)};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_time();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'hFF;
      2: return 8'($urandom);
      default: return 8'($urandom_range(0, 40));
    endcase
  endfunction

  // no channels driven after reset: symbols come out all low
  task automatic test_reset_defaults();
    send_req(REQ_SYMBOL, 3'b111, 8'h00, 8'h00, 8'h00);
    send_req(REQ_BYTE, 3'b000, 8'hFF, 8'h00, 8'hA5);
    send_req(REQ_RESET, 3'b000, 8'h00, 8'h00, 8'h00);
    send_req(REQ_UNUSED, 3'b111, 8'hFF, 8'hFF, 8'hFF);
    drain();
  endtask

  task automatic test_symbol_patterns();
    load_timing(8'd8, 8'd16, 8'd25, 16'd1000, 3'b111);
    for (int b = 0; b < 8; b++) begin
      send_req(REQ_SYMBOL, 3'(b), 8'h00, 8'h00, 8'h00);
    end
    send_req(REQ_BYTE, 3'b000, 8'hA5, 8'h3C, 8'h0F);
    send_req(REQ_RESET, 3'b000, 8'h00, 8'h00, 8'h00);
    drain();
  endtask

  // one-bit code shorter, clamped low time, equal high times, zero and full timing
  task automatic test_timing_corners();
    load_timing(8'd20, 8'd6, 8'd10, 16'd0, 3'b111);
    send_req(REQ_SYMBOL, 3'b101, 8'h00, 8'h00, 8'h00);
    send_req(REQ_BYTE, 3'b000, 8'h81, 8'h7E, 8'hC3);
    drain();
    load_timing(8'd12, 8'd12, 8'd12, 16'hFFFF, 3'b101);
    send_req(REQ_SYMBOL, 3'b011, 8'h00, 8'h00, 8'h00);
    send_req(REQ_RESET, 3'b000, 8'h00, 8'h00, 8'h00);
    drain();
    load_timing(8'd0, 8'd0, 8'd0, 16'd0, 3'b010);
    send_req(REQ_SYMBOL, 3'b010, 8'h00, 8'h00, 8'h00);
    send_req(REQ_SYMBOL, 3'b101, 8'h00, 8'h00, 8'h00);
    drain();
    load_timing(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 3'b111);
    send_req(REQ_SYMBOL, 3'b110, 8'h00, 8'h00, 8'h00);
    send_req(REQ_BYTE, 3'b000, 8'hFF, 8'h00, 8'h55);
    drain();
  endtask

  task automatic test_random_traffic();
    int count;
    int r;
    logic [1:0] kind;
    logic [15:0] gap_len;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0: gap_len = 16'd0;
        1: gap_len = 16'hFFFF;
        default: gap_len = 16'($urandom);
      endcase
      load_timing(pick_time(), pick_time(), pick_time(), gap_len,
                  ($urandom_range(0, 1) != 0) ? 3'b111 : 3'($urandom_range(0, 7)));
      count = 0;
      while (count < 27) begin
        if (count % 11 == 0) begin
          in_gaps_on = $urandom_range(0, 2) != 0;
          out_stalls_on = $urandom_range(0, 2) != 0;
        end
        r = $urandom_range(0, 99);
        kind = (r < 40) ? REQ_SYMBOL : (r < 75) ? REQ_BYTE : (r < 90) ? REQ_RESET : REQ_UNUSED;
        send_req(kind, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        if (kind != REQ_UNUSED) count++;
      end
      drain();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 2'd0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_symbol_patterns();
    test_timing_corners();
    test_random_traffic();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
